### src/streaming_median_sorter_assert.svh
// assertion macros used by the top-level rtl file
`ifndef STREAMING_MEDIAN_SORTER_ASSERT_SVH
`define STREAMING_MEDIAN_SORTER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, sampled on clk, off during reset
`define SMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sms assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sms assertion failed");

`else

`define SMS_ASSERT_NOW(label, ante, cons)
`define SMS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### src/sms_pkg.sv
`default_nettype none

package sms_pkg;

  localparam int VAL_W     = 32;
  localparam int MED_W     = 33;
  localparam int CNT_OUT_W = 7;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [MED_W-1:0] med_t;

  // per-cycle command broadcast along the cell row
  typedef struct packed {
    logic ins;    // insert value into the sorted row
    logic shift;  // move every cell one place toward cell 0
    logic clr;    // drop all occupancy
    val_t value;  // value being inserted
  } cell_ctrl_t;

endpackage

`default_nettype wire

### src/sms_if.sv
`default_nettype none

// input beat: one value, plus the set-closing mark
interface sms_in_if;
  logic                valid;
  logic                ready;
  sms_pkg::val_t       value;
  logic                last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// result beat: median at double scale with set information
interface sms_out_if;
  logic                               valid;
  logic                               ready;
  sms_pkg::med_t                      median_times_two;
  logic [sms_pkg::CNT_OUT_W-1:0]      element_count;
  logic                               overflowed;

  modport source (output valid, output median_times_two, output element_count,
                  output overflowed, input ready);
  modport sink   (input valid, input median_times_two, input element_count,
                  input overflowed, output ready);
endinterface

`default_nettype wire

### src/sms_cell.sv
`default_nettype none

module sms_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sms_pkg::cell_ctrl_t ctrl,
  input  wire logic                left_gt,
  input  wire logic                left_occ,
  input  wire sms_pkg::val_t       left_val,
  input  wire sms_pkg::val_t       right_val,
  output sms_pkg::val_t            val,
  output logic                     occ,
  output logic                     gt
);
  import sms_pkg::*;

  val_t val_r, val_nxt;
  logic occ_r, occ_nxt;

  // held value is strictly above the incoming one
  assign gt  = occ_r && (val_r > ctrl.value);
  assign val = val_r;
  assign occ = occ_r;

  // insert: take the left neighbor when the row shifts past us,
  // the new value at the insertion point, else hold
  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    if (ctrl.ins) begin
      if (left_gt) begin
        val_nxt = left_val;
      end else if (gt || (!occ_r && left_occ)) begin
        val_nxt = ctrl.value;
      end
      occ_nxt = occ_r | left_occ;
    end else if (ctrl.shift) begin
      val_nxt = right_val;
    end
    if (ctrl.clr) begin
      occ_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

### src/streaming_median_sorter.sv
`default_nettype none
`include "streaming_median_sorter_assert.svh"

// Streaming median sorter. Signed 32-bit values arrive one beat per cycle and
// drop straight into a row of CAPACITY compare-and-shift cells that keeps them
// in ascending order, so loading runs at one value per clock. The beat with
// last set closes the set, and the input then stalls while the row shifts toward
// its head until the middle value sits in the first cell (n = values kept);
// the median is formed there as twice the middle value (odd n) or the exact
// sum of the two middle values (even n).
// The result is 33-bit signed with one fractional bit, alongside the kept
// count (low 7 bits) and a flag for values dropped once the row was full.
// A result waiting on the output does not hold up loading of the next set
// unless that set closes before the result is taken.
module streaming_median_sorter #(
  parameter int CAPACITY = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sms_in_if.sink    in_ch,
  sms_out_if.source out_ch
);
  import sms_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SHIFT,
    ST_SUM
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] shifts_r;
  logic             ovf_r;
  logic             set_ovf_r;
  logic             out_valid_r;
  med_t             med_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic             out_ovf_r;

  logic             in_beat;
  logic             full;
  logic [CNT_W-1:0] count_after;
  logic             sum_go;
  cell_ctrl_t       ctrl;

  val_t             head_val;
  logic             head_occ;
  logic             head_gt;
  val_t             tail_val;

  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(CAPACITY));
  assign count_after = full ? count_r : count_r + CNT_W'(1);
  assign sum_go      = (state_r == ST_SUM) && (!out_valid_r || out_ch.ready);

  // command to the cell row
  always_comb begin
    ctrl.ins   = in_beat && !full;
    ctrl.shift = (state_r == ST_SHIFT) && (shifts_r != '0);
    ctrl.clr   = sum_go;
    ctrl.value = in_ch.value;
  end

  // head of the row sees an occupied, never-greater neighbor
  assign head_gt  = 1'b0;
  assign head_occ = 1'b1;
  assign head_val = '0;
  // tail feed for shifting toward the head
  assign tail_val = '0;

  // cell i takes its left neighbor from cell i-1 and its right one from cell i+1
  val_t row_val [CAPACITY];
  logic row_occ [CAPACITY];
  logic row_gt  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    val_t left_v;
    logic left_o;
    logic left_g;
    val_t right_v;
    if (i == 0) begin : g_head
      assign left_v = head_val;
      assign left_o = head_occ;
      assign left_g = head_gt;
    end else begin : g_body
      assign left_v = row_val[i-1];
      assign left_o = row_occ[i-1];
      assign left_g = row_gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = tail_val;
    end else begin : g_mid
      assign right_v = row_val[i+1];
    end
    sms_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .left_gt   (left_g),
      .left_occ  (left_o),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (row_val[i]),
      .occ       (row_occ[i]),
      .gt        (row_gt[i])
    );
  end

  // two head values after the shift phase
  val_t head0;
  val_t head1;
  assign head0 = row_val[0];
  if (CAPACITY > 1) begin : g_h1
    assign head1 = row_val[1];
  end else begin : g_h1_none
    assign head1 = tail_val;
  end

  // control sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !sum_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_LOAD: begin
          if (in_beat) begin
            count_r <= count_after;
            if (full) begin
              ovf_r <= 1'b1;
            end
            if (in_ch.last) begin
              n_r       <= count_after;
              shifts_r  <= (count_after - CNT_W'(1)) >> 1;
              set_ovf_r <= full || ovf_r;
              state_r   <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          if (shifts_r == '0) begin
            state_r <= ST_SUM;
          end else begin
            shifts_r <= shifts_r - CNT_W'(1);
          end
        end
        ST_SUM: begin
          if (sum_go) begin
            if (n_r[0]) begin
              med_r <= {head0, 1'b0};
            end else begin
              med_r <= MED_W'(head0) + MED_W'(head1);
            end
            out_cnt_r   <= CNT_OUT_W'(n_r);
            out_ovf_r   <= set_ovf_r;
            out_valid_r <= 1'b1;
            count_r     <= '0;
            ovf_r       <= 1'b0;
            state_r     <= ST_LOAD;
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.median_times_two = med_r;
  assign out_ch.element_count    = out_cnt_r;
  assign out_ch.overflowed       = out_ovf_r;

  // a beat into a full row marks the set as overflowed
  `SMS_ASSERT_NEXT(a_ovf_on_full, in_beat && full && !in_ch.last, ovf_r)
  // the shift phase runs until its counter reaches zero
  `SMS_ASSERT_NEXT(a_shift_holds, (state_r == ST_SHIFT) && (shifts_r != '0),
                   state_r == ST_SHIFT)
  // closing a set leaves a fresh empty row and a pending result
  `SMS_ASSERT_NEXT(a_sum_result, sum_go,
                   out_valid_r && (count_r == '0) && !ovf_r && (state_r == ST_LOAD))
  // the count never runs past the row length
  `SMS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY))

endmodule

`default_nettype wire
